// ----- src/tpv_pkg.sv -----
// Shared types, constants and tree helper functions for the tree PLRU victim block.
`default_nettype none

package tpv_pkg;

	localparam int WAYS   = 8;
	localparam int LEVELS = 3;
	localparam int NODES  = WAYS - 1;
	localparam int NODE_W = $clog2(NODES);
	localparam int TRY_W  = $clog2(WAYS);
	localparam int CNT_W  = $clog2(WAYS + 1);

	typedef logic [NODES-1:0]  tree_t;
	typedef logic [LEVELS-1:0] way_t;
	typedef logic [WAYS-1:0]   mask_t;
	typedef logic [1:0]        cmd_code_t;
	typedef logic [5:0]        set_t;
	typedef logic [3:0]        limit_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [TRY_W-1:0]  try_t;

	localparam cmd_code_t CMD_TOUCH  = 2'd0;
	localparam cmd_code_t CMD_INVAL  = 2'd1;
	localparam cmd_code_t CMD_VICTIM = 2'd2;

	localparam limit_t LIMIT_RESET = 4'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic clear_wr;
		logic load_scratch;
		logic step;
		logic finish;
		logic in_search;
	} tpv_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic needs_search;
		logic hit;
		logic last_try;
	} tpv_status_t;

	// Point every node on a way's path toward it or away from it
	function automatic tree_t set_path(tree_t tree, way_t w, logic toward);
		tree_t             t;
		logic [NODE_W-1:0] idx;
		logic              b;
		t   = tree;
		idx = '0;
		for (int l = 0; l < LEVELS; l++) begin
			b      = w[LEVELS-1-l];
			t[idx] = toward ? b : ~b;
			idx    = NODE_W'(2 * idx + 1 + b);
		end
		return t;
	endfunction

	// Follow node bits from the root down to a leaf
	function automatic way_t walk(tree_t tree);
		logic [NODE_W-1:0] idx;
		way_t              w;
		logic              b;
		idx = '0;
		w   = '0;
		for (int l = 0; l < LEVELS; l++) begin
			b   = tree[idx];
			w   = {w[LEVELS-2:0], b};
			idx = NODE_W'(2 * idx + 1 + b);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- src/tpv_req_if.sv -----
// Request channel: valid/ready handshake with the command payload.
`default_nettype none

interface tpv_req_if;
	import tpv_pkg::*;

	logic      valid;
	logic      ready;
	cmd_code_t command;
	set_t      set_index;
	way_t      way;
	mask_t     preserve_mask;

	modport source (output valid, command, set_index, way, preserve_mask, input ready);
	modport sink   (input valid, command, set_index, way, preserve_mask, output ready);
endinterface

`default_nettype wire

// ----- src/tpv_rsp_if.sv -----
// Result channel: valid/ready handshake with the victim payload.
`default_nettype none

interface tpv_rsp_if;
	import tpv_pkg::*;

	logic valid;
	logic ready;
	way_t victim_way;
	logic victim_valid;

	modport source (output valid, victim_way, victim_valid, input ready);
	modport sink   (input valid, victim_way, victim_valid, output ready);
endinterface

`default_nettype wire

// ----- src/tpv_ctrl.sv -----
// Controller state machine: clear pass, request intake, lookup, victim search, result hand-off.
`default_nettype none

module tpv_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire tpv_pkg::tpv_status_t st,
	output tpv_pkg::tpv_cmd_t       cmd
);
	import tpv_pkg::*;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;
	localparam logic [1:0] ST_SEARCH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = ~out_valid_q | rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (st.needs_search) begin
					cmd.load_scratch = 1'b1;
					state_d          = ST_SEARCH;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				cmd.in_search = 1'b1;
				if (st.hit || st.last_try) begin
					if (out_free) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state; hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tpv_dp.sv -----
// Datapath: tree memory, preserve limit, request capture, scratch-tree search and result register.
`default_nettype none

module tpv_dp #(
	parameter int NUM_SETS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire tpv_pkg::limit_t      cfg_wdata,
	input  wire tpv_pkg::cmd_code_t   req_command,
	input  wire tpv_pkg::set_t        req_set_index,
	input  wire tpv_pkg::way_t        req_way,
	input  wire tpv_pkg::mask_t       req_preserve_mask,
	input  wire tpv_pkg::tpv_cmd_t    cmd,
	output tpv_pkg::tpv_status_t      st,
	output tpv_pkg::way_t             victim_way,
	output logic                      victim_valid
);
	import tpv_pkg::*;

	localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

	tree_t             mem [NUM_SETS];
	logic [SET_AW-1:0] req_addr;
	logic [SET_AW-1:0] addr_q;
	logic [SET_AW-1:0] clr_q;
	logic [SET_AW-1:0] wr_addr;
	tree_t             wr_data;
	logic              wr_en;
	limit_t            lim_q;
	cmd_code_t         cmd_q;
	logic              set_ok_q;
	way_t              way_q;
	mask_t             mask_q;
	tree_t             rd_q;
	tree_t             scratch_q;
	try_t              try_q;
	way_t              out_way_q;
	logic              out_vv_q;
	tree_t             tree;
	tree_t             new_tree;
	logic              update;
	count_t            cnt;
	way_t              cand;
	way_t              fallback;
	way_t              res_way;

	assign req_addr = SET_AW'(req_set_index);
	assign tree     = set_ok_q ? rd_q : '0;

	// Count preserved ways
	always_comb begin
		cnt = '0;
		for (int w = 0; w < WAYS; w++) begin
			cnt = cnt + count_t'(mask_q[w]);
		end
	end

	// Lowest unpreserved way, else way 0
	always_comb begin
		fallback = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!mask_q[w]) fallback = way_t'(w);
		end
	end

	assign cand = walk(scratch_q);

	// Status toward the controller
	always_comb begin
		st.clear_last   = (clr_q == SET_AW'(NUM_SETS - 1));
		st.needs_search = (cmd_q == CMD_VICTIM) && (cnt != '0)
			&& (cnt != count_t'(WAYS)) && (32'(cnt) <= 32'(lim_q));
		st.hit          = ~mask_q[cand];
		st.last_try     = (try_q == try_t'(WAYS - 1));
	end

	// Result selection
	always_comb begin
		if (cmd.in_search) begin
			res_way = st.hit ? cand : fallback;
		end else if (cmd_q == CMD_VICTIM) begin
			res_way = walk(tree);
		end else begin
			res_way = '0;
		end
	end

	// Tree write-back for touch and invalidate
	assign update   = ((cmd_q == CMD_TOUCH) || (cmd_q == CMD_INVAL)) && set_ok_q;
	assign new_tree = set_path(rd_q, way_q, cmd_q == CMD_INVAL);
	assign wr_en    = cmd.clear_wr | (cmd.finish & update & ~cmd.in_search);
	assign wr_addr  = cmd.clear_wr ? clr_q : addr_q;
	assign wr_data  = cmd.clear_wr ? '0 : new_tree;

	// Tree memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.accept) rd_q <= mem[req_addr];
	end

	// Control registers: limit, clear counter, try counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RESET;
			clr_q <= '0;
			try_q <= '0;
		end else begin
			if (cfg_we) lim_q <= cfg_wdata;
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.load_scratch) begin
				try_q <= '0;
			end else if (cmd.step) begin
				try_q <= try_q + 1'b1;
			end
		end
	end

	// Capture request, walk the scratch tree, load the result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q    <= req_command;
			set_ok_q <= (32'(req_set_index) < NUM_SETS);
			way_q    <= req_way;
			mask_q   <= req_preserve_mask;
			addr_q   <= req_addr;
		end
		if (cmd.load_scratch) begin
			scratch_q <= tree;
		end else if (cmd.step) begin
			scratch_q <= set_path(scratch_q, cand, 1'b0);
		end
		if (cmd.finish) begin
			out_way_q <= res_way;
			out_vv_q  <= (cmd_q == CMD_VICTIM);
		end
	end

	assign victim_way   = out_way_q;
	assign victim_valid = out_vv_q;

endmodule

`default_nettype wire

// ----- src/tree_plru_preserve_victim_core.sv -----
// Top level of the tree pseudo-LRU replacement block with preserve bits.
//
// One 7-bit pseudo-LRU tree per set lives in an on-chip memory. After reset a
// clearing pass zeroes all NUM_SETS sets, one set per cycle; no request is
// taken during it (preserve_limit writes are). Each request then returns
// exactly one result. A touch, invalidate, unused command or plain victim
// gets its tree through the registered memory read, then updates or walks it
// as the result is loaded into the output register, once that register is
// free. A victim request with some but not all and at most preserve_limit ways
// preserved walks a scratch copy, one walk per cycle, stepping over at most 7
// preserved leaves, else taking the lowest unpreserved way. One request is in
// work at a time; the next one is taken in the cycle after its result is loaded
// into the output register, even while that result still waits to be taken.
`default_nettype none

module tree_plru_preserve_victim_core #(
	parameter int NUM_SETS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire tpv_pkg::limit_t cfg_wdata,
	tpv_req_if.sink              req,
	tpv_rsp_if.source            rsp
);
	import tpv_pkg::*;

	tpv_cmd_t    cmd;
	tpv_status_t st;

	tpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tpv_dp #(
		.NUM_SETS (NUM_SETS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.req_command       (req.command),
		.req_set_index     (req.set_index),
		.req_way           (req.way),
		.req_preserve_mask (req.preserve_mask),
		.cmd               (cmd),
		.st                (st),
		.victim_way        (rsp.victim_way),
		.victim_valid      (rsp.victim_valid)
	);

endmodule

`default_nettype wire

// ----- src/tpv_checker.sv -----
// Port-level checks for the tree PLRU victim block, bound to its top level.
`default_nettype none

module tpv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [2:0] victim_way,
	input wire logic       victim_valid
);

	// A held result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// A held result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(victim_way) && $stable(victim_valid))
		else $error("result payload changed while stalled");

	// Results that do not answer a victim request carry way 0
	a_non_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !victim_valid |-> victim_way == 3'd0)
		else $error("non-victim result with nonzero way");

	// One request in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

endmodule

bind tree_plru_preserve_victim_core tpv_checker u_tpv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.victim_way   (rsp.victim_way),
	.victim_valid (rsp.victim_valid)
);

`default_nettype wire
